>>> hdl/nta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nta_pkg;

  // Default table geometry.
  localparam int NUM_SLOTS_DEF  = 1024;
  localparam int SLOT_BYTES_DEF = 32;

  // Width of the text length counter; holds up to 511 characters.
  localparam int LEN_W = 9;

  // Id window that a free request may address.
  localparam logic [15:0] ID_BASE  = 16'h8000;
  localparam logic [15:0] ID_LIMIT = 16'h9000;

  // Tag bit that lets a request store a duplicate name.
  localparam int TAG_DUP_BIT = 7;

  // Result status codes.
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_IN_USE = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  text_char;
    logic        text_last;
    logic [7:0]  base_tag;
    logic [15:0] free_id;
  } req_t;

  typedef struct packed {
    logic [15:0] name_id;
    logic [1:0]  status;
  } res_t;

  // Commands handed from the front part to the back part.
  typedef enum logic [1:0] {
    OP_FINISH = 2'd0,
    OP_FREE   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [LEN_W-1:0] len;
    logic [7:0]      tag;
    logic [15:0]     id;
  } cmd_t;

  // Status of the back part seen by the top level.
  typedef struct packed {
    logic init_busy;
    logic fin_done;
  } back_stat_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_MOD,
    S_FREE,
    S_DUP_FRD,
    S_DUP_FCK,
    S_DUP_BRD,
    S_DUP_BCK,
    S_FIND_RD,
    S_FIND_CK,
    S_COPY_RD,
    S_COPY_WR,
    S_TERM
  } back_state_t;

endpackage
`default_nettype wire

>>> hdl/nta_front.sv
`timescale 1ns / 1ps
`default_nettype none
module nta_front #(
  parameter int SLOT_BYTES = 32,
  localparam int BW = $clog2(SLOT_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire nta_pkg::req_t req,
  output logic               push,
  output nta_pkg::cmd_t      cmd,
  input  wire logic [BW-1:0] buf_addr,
  output logic [7:0]         buf_data
);
  import nta_pkg::*;

  logic [LEN_W-1:0] len, len_next;
  logic             ended, ended_next;
  logic             wr_en;
  logic [7:0]       tbuf [SLOT_BYTES];

  // Collect text characters and map requests to commands, if any.
  always_comb begin
    len_next   = len;
    ended_next = ended;
    wr_en      = 1'b0;
    push       = 1'b0;
    cmd.op     = OP_FINISH;
    cmd.len    = len;
    cmd.tag    = req.base_tag;
    cmd.id     = req.free_id;
    if (accept) begin
      unique case (req.action)
        ACT_ALLOC: begin
          if (!ended) begin
            if (req.text_char == 8'd0) begin
              ended_next = 1'b1;
            end else if (len < LEN_W'(SLOT_BYTES)) begin
              wr_en    = 1'b1;
              len_next = len + 1'b1;
            end
          end
          if (req.text_last) begin
            push       = 1'b1;
            cmd.op     = OP_FINISH;
            cmd.len    = len_next;
            len_next   = '0;
            ended_next = 1'b0;
          end
        end
        ACT_FREE: begin
          if (req.free_id >= ID_BASE && req.free_id < ID_LIMIT) begin
            push   = 1'b1;
            cmd.op = OP_FREE;
          end
        end
        ACT_CLEAR: begin
          push   = 1'b1;
          cmd.op = OP_CLEAR;
        end
        ACT_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= '0;
      ended <= 1'b0;
    end else begin
      len   <= len_next;
      ended <= ended_next;
    end
  end

  // Text buffer with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbuf[len[BW-1:0]] <= req.text_char;
    end
    buf_data <= tbuf[buf_addr];
  end

endmodule
`default_nettype wire

>>> hdl/nta_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module nta_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire nta_pkg::cmd_t din,
  input  wire logic          pop,
  output nta_pkg::cmd_t      dout,
  output logic               empty,
  output logic               full
);
  import nta_pkg::*;

  cmd_t       entry [2];
  logic       rp, wp;
  logic [1:0] count;

  assign dout  = entry[rp];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  // Two-entry command queue between the front and back parts.
  always_ff @(posedge clk) begin
    if (rst) begin
      rp    <= 1'b0;
      wp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= din;
    end
  end

endmodule
`default_nettype wire

>>> hdl/nta_back.sv
`timescale 1ns / 1ps
`default_nettype none
module nta_back #(
  parameter int NUM_SLOTS  = 1024,
  parameter int SLOT_BYTES = 32,
  localparam int BW = $clog2(SLOT_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire nta_pkg::cmd_t cmd,
  output logic               pop,
  output logic [BW-1:0]      buf_addr,
  input  wire logic [7:0]    buf_data,
  output logic               done,
  output nta_pkg::res_t      result,
  output nta_pkg::back_stat_t stat
);
  import nta_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int AW = SW + BW;
  localparam int QS = SW + 16;
  localparam longint RECIP_L =
    ((longint'(1) << QS) + longint'(NUM_SLOTS) - longint'(1)) / longint'(NUM_SLOTS);
  localparam logic [17:0] RECIP = 18'(RECIP_L);

  back_state_t   state, state_next;
  logic [SW-1:0] slot, slot_next;
  logic [BW-1:0] idx, idx_next;
  logic [BW-1:0] nlen, nlen_next;
  logic [15:0]   quo, quo_next;
  logic [33:0]   quo_prod;
  logic [31:0]   quo_back;
  cmd_t          cur, cur_next;
  logic          done_next;
  res_t          result_next;

  logic          flag_we, flag_wd, flag_q;
  logic [SW-1:0] flag_wa;
  logic          store_we;
  logic [AW-1:0] store_wa;
  logic [7:0]    store_wd, store_q, expect_byte;
  logic          flags [NUM_SLOTS];
  logic [7:0]    store [NUM_SLOTS << BW];
  logic          last_slot, at_end;

  // A text takes part in the duplicate search only when it is non-empty,
  // fits a slot with its terminator, and the tag does not allow duplicates.
  function automatic logic dup_check(input cmd_t c);
    dup_check = !c.tag[TAG_DUP_BIT] && (c.len != '0) &&
                (c.len <= LEN_W'(SLOT_BYTES - 1));
  endfunction

  assign buf_addr       = idx;
  assign last_slot      = (slot == SW'(NUM_SLOTS - 1));
  assign at_end         = (LEN_W'(idx) == cur.len);
  assign expect_byte    = at_end ? 8'd0 : buf_data;
  assign stat.init_busy = (state == S_INIT);
  assign stat.fin_done  = done;

  // Slot index of a free request: the quotient by NUM_SLOTS comes from a
  // reciprocal multiplication, the remainder from a multiply and subtract
  // on the following cycle.
  assign quo_prod = {18'd0, cur.id} * {16'd0, RECIP};
  assign quo_back = {16'd0, quo} * 32'(NUM_SLOTS);

  // Sequencer for reset initialisation and for finish, free and clear commands.
  always_comb begin
    state_next  = state;
    slot_next   = slot;
    idx_next    = idx;
    nlen_next   = nlen;
    quo_next    = quo;
    cur_next    = cur;
    done_next   = 1'b0;
    result_next = result;
    pop         = 1'b0;
    flag_we     = 1'b0;
    flag_wa     = slot;
    flag_wd     = 1'b0;
    store_we    = 1'b0;
    store_wa    = {slot, idx};
    store_wd    = 8'd0;
    unique case (state)
      S_INIT, S_CLEAR: begin
        flag_we = 1'b1;
        if (last_slot) begin
          state_next = S_IDLE;
        end else begin
          slot_next = slot + 1'b1;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          pop       = 1'b1;
          cur_next  = cmd;
          slot_next = '0;
          idx_next  = '0;
          unique case (cmd.op)
            OP_FINISH: state_next = dup_check(cmd) ? S_DUP_FRD : S_FIND_RD;
            OP_FREE: state_next = S_MOD;
            OP_CLEAR: state_next = S_CLEAR;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_MOD: begin
        quo_next   = 16'(quo_prod >> QS);
        state_next = S_FREE;
      end
      S_FREE: begin
        flag_we    = 1'b1;
        flag_wa    = cur.id[SW-1:0] - quo_back[SW-1:0];
        state_next = S_IDLE;
      end
      S_DUP_FRD: state_next = S_DUP_FCK;
      S_DUP_FCK: begin
        if (flag_q) begin
          idx_next   = '0;
          state_next = S_DUP_BRD;
        end else if (last_slot) begin
          slot_next  = '0;
          state_next = S_FIND_RD;
        end else begin
          slot_next  = slot + 1'b1;
          state_next = S_DUP_FRD;
        end
      end
      S_DUP_BRD: state_next = S_DUP_BCK;
      S_DUP_BCK: begin
        priority if (store_q != expect_byte) begin
          if (last_slot) begin
            slot_next  = '0;
            state_next = S_FIND_RD;
          end else begin
            slot_next  = slot + 1'b1;
            state_next = S_DUP_FRD;
          end
        end else if (at_end) begin
          done_next   = 1'b1;
          result_next = '{name_id: 16'd0, status: STATUS_IN_USE};
          state_next  = S_IDLE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_DUP_BRD;
        end
      end
      S_FIND_RD: state_next = S_FIND_CK;
      S_FIND_CK: begin
        if (!flag_q) begin
          idx_next = '0;
          if (cur.len > LEN_W'(SLOT_BYTES - 1)) begin
            nlen_next = BW'(SLOT_BYTES - 1);
          end else begin
            nlen_next = cur.len[BW-1:0];
          end
          state_next = (nlen_next == '0) ? S_TERM : S_COPY_RD;
        end else if (last_slot) begin
          done_next   = 1'b1;
          result_next = '{name_id: 16'd0, status: STATUS_FULL};
          state_next  = S_IDLE;
        end else begin
          slot_next  = slot + 1'b1;
          state_next = S_FIND_RD;
        end
      end
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: begin
        store_we = 1'b1;
        store_wd = buf_data;
        if (idx == nlen - 1'b1) begin
          state_next = S_TERM;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_COPY_RD;
        end
      end
      S_TERM: begin
        store_we    = 1'b1;
        store_wa    = {slot, nlen};
        flag_we     = 1'b1;
        flag_wd     = (nlen != '0);
        done_next   = 1'b1;
        result_next.status  = STATUS_OK;
        result_next.name_id = 16'(ID_BASE + (16'(slot) | {cur.tag[6:0], 9'd0}));
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      slot  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    nlen   <= nlen_next;
    quo    <= quo_next;
    cur    <= cur_next;
    result <= result_next;
  end

  // Slot occupancy flags: set when the first byte of the slot is non-zero.
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flags[flag_wa] <= flag_wd;
    end
    flag_q <= flags[slot];
  end

  // Name text store, one row of 2**BW bytes per slot.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[store_wa] <= store_wd;
    end
    store_q <= store[{slot, idx}];
  end

endmodule
`default_nettype wire

>>> hdl/name_table_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Name table allocator. A request is taken when start is high and busy is low; the
// result of an allocate request appears on result for one cycle with done, and the
// receiver must take it then. Text characters, free and clear-all requests are
// handled at the front part, which hands commands to the back part through a
// two-entry queue. After the last character of an allocate request, busy stays
// high until its result: the back part may first search the occupied slots for a
// duplicate name, then searches for an empty slot and copies the text into it with
// a terminator. The slot flag and text memories each have a single read port.
// A free clears the flag of the slot that its id selects, a clear-all clears every
// slot flag. After reset the slot flags are cleared, during which busy is high.
module name_table_allocator #(
  parameter int NUM_SLOTS  = nta_pkg::NUM_SLOTS_DEF,
  parameter int SLOT_BYTES = nta_pkg::SLOT_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire nta_pkg::req_t request,
  output logic               done,
  output nta_pkg::res_t      result
);
  import nta_pkg::*;

  localparam int BW = $clog2(SLOT_BYTES);

  logic          accept, push, pop, q_empty, q_full, fin_pend;
  cmd_t          f_cmd, q_cmd;
  logic [BW-1:0] buf_addr;
  logic [7:0]    buf_data;
  back_stat_t    stat;

  assign accept = start && !busy;
  assign busy   = stat.init_busy || q_full || fin_pend;

  // An allocate request holds the text buffer until its result is out.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_pend <= 1'b0;
    end else if (push && f_cmd.op == OP_FINISH) begin
      fin_pend <= 1'b1;
    end else if (stat.fin_done) begin
      fin_pend <= 1'b0;
    end
  end

  nta_front #(.SLOT_BYTES(SLOT_BYTES)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .req(request),
    .push(push), .cmd(f_cmd), .buf_addr(buf_addr), .buf_data(buf_data)
  );

  nta_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(f_cmd), .pop(pop),
    .dout(q_cmd), .empty(q_empty), .full(q_full)
  );

  nta_back #(.NUM_SLOTS(NUM_SLOTS), .SLOT_BYTES(SLOT_BYTES)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(!q_empty), .cmd(q_cmd), .pop(pop),
    .buf_addr(buf_addr), .buf_data(buf_data), .done(done), .result(result),
    .stat(stat)
  );

  // A failed allocation always reports id zero.
  a_fail_id: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == STATUS_OK) || (result.name_id == 16'd0))
    else $error("failed allocation with non-zero id");

  // Every result belongs to an outstanding allocate request.
  a_done_pend: assert property (@(posedge clk) disable iff (rst)
    done |-> fin_pend)
    else $error("result without pending allocate request");

  // The queue never takes a command while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("command pushed into full queue");

endmodule
`default_nettype wire
